>>> sv/fprx_pkg.sv
package fprx_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CrcW    = 16;
	localparam int unsigned PosW    = 9;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;

	localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

	// Byte positions of the fixed header.
	localparam logic [PosW-1:0] PosStart = 9'd0;
	localparam logic [PosW-1:0] PosSrc   = 9'd1;
	localparam logic [PosW-1:0] PosDst   = 9'd2;
	localparam logic [PosW-1:0] PosLen   = 9'd3;
	localparam logic [PosW-1:0] PosType  = 9'd4;

	typedef enum logic [2:0] {
		ST_NOT_READY = 3'd0,
		ST_READY     = 3'd1,
		ST_INVALID   = 3'd2,
		ST_WRONG_ADR = 3'd3,
		ST_ERROR     = 3'd4
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_OWN_ADDR  = 2'd0,
		CFG_START     = 2'd1,
		CFG_CRC_SEED  = 2'd2,
		CFG_MAX_LEN   = 2'd3
	} cfg_idx_t;

	// Control from the parser to the CRC unit.
	typedef struct packed {
		logic load;    // reload from seed (start byte seen)
		logic update;  // fold in the current byte
	} crc_ctl_t;

	// CRC-16-CCITT, MSB first, one byte.
	function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] b);
		logic [CrcW-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < ByteW; i++) begin
			if (c[CrcW-1]) begin
				c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[CrcW-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/fprx_crc_unit.sv
module fprx_crc_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fprx_pkg::crc_ctl_t              ctl,
	input  logic [fprx_pkg::CrcW-1:0]       seed,
	input  logic [fprx_pkg::ByteW-1:0]      data,
	output logic [fprx_pkg::CrcW-1:0]       crc
);
	import fprx_pkg::*;

	logic [CrcW-1:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.load) begin
			crc_q <= seed;
		end else if (ctl.update) begin
			crc_q <= crc16_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

>>> sv/framed_packet_receiver_crc16_core.sv
// Byte-stream packet deframer with CRC-16-CCITT check. Each transfer on the
// input channel carries one received byte (or a restart request) and yields
// exactly one transfer on the output channel: a status, the payload byte with
// its index when the byte belonged to the payload, and the header fields held
// for the current packet. Frame layout: start byte, source, destination,
// length, type, payload, CRC MSB, CRC LSB. The CRC (poly 0x1021, MSB first,
// seeded from crc_seed when the start byte is taken) covers source through the
// last payload byte. One byte per clock while the output is not stalled: the
// parse step and the byte-wide CRC update sit between the state registers and
// the result register, and a new byte is taken in the same cycle a held result
// leaves, so throughput is one transfer per cycle. Registers are written through
// cfg_we/cfg_index/cfg_data and take effect at the byte that samples them;
// write them only while no byte is in flight.
module framed_packet_receiver_crc16_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [fprx_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [fprx_pkg::CfgW-1:0]       cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [fprx_pkg::ByteW-1:0]      rx_byte,
	input  logic                            restart,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic                            payload_valid,
	output logic [fprx_pkg::ByteW-1:0]      payload_byte,
	output logic [fprx_pkg::ByteW-1:0]      payload_index,
	output logic [fprx_pkg::ByteW-1:0]      source_address,
	output logic [fprx_pkg::ByteW-1:0]      dest_address,
	output logic [fprx_pkg::ByteW-1:0]      payload_length,
	output logic [fprx_pkg::ByteW-1:0]      packet_type
);
	import fprx_pkg::*;

	// configuration registers
	logic [ByteW-1:0] own_addr_q;
	logic [ByteW-1:0] start_val_q;
	logic [CrcW-1:0]  crc_seed_q;
	logic [ByteW-1:0] max_len_q;

	// parse state
	logic [PosW-1:0]  pos_q;
	logic [ByteW-1:0] src_q;
	logic [ByteW-1:0] dst_q;
	logic [ByteW-1:0] len_q;
	logic [ByteW-1:0] type_q;
	logic [ByteW-1:0] chk_msb_q;   // only the MSB of the received check is kept

	// result register
	logic             out_valid_q;
	status_t          status_q;
	logic             pvalid_q;
	logic [ByteW-1:0] pbyte_q;
	logic [ByteW-1:0] pindex_q;
	logic [ByteW-1:0] src_out_q;
	logic [ByteW-1:0] dst_out_q;
	logic [ByteW-1:0] len_out_q;
	logic [ByteW-1:0] type_out_q;

	logic             accept;
	logic [CrcW-1:0]  crc;
	crc_ctl_t         crc_ctl;

	// next-state / result logic
	logic [PosW-1:0]  pos_d;
	logic [ByteW-1:0] src_d, dst_d, len_d, type_d, chk_msb_d;
	status_t          status_d;
	logic             pvalid_d;
	logic [ByteW-1:0] pindex_d;
	logic [PosW-1:0]  pay_end;      // first position after the payload
	logic [PosW-1:0]  pos_inc;

	// output register frees whenever its content leaves or it is empty
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign pay_end = {1'b0, len_q} + (PosType + PosW'(1));
	assign pos_inc = pos_q + PosW'(1);

	always_comb begin
		pos_d     = pos_q;
		src_d     = src_q;
		dst_d     = dst_q;
		len_d     = len_q;
		type_d    = type_q;
		chk_msb_d = chk_msb_q;
		status_d  = ST_NOT_READY;
		pvalid_d  = 1'b0;
		pindex_d  = '0;
		crc_ctl   = '0;

		if (restart) begin
			pos_d = PosStart;
		end else if (pos_q == PosStart) begin
			if (rx_byte == start_val_q) begin
				src_d        = '0;
				dst_d        = '0;
				len_d        = '0;
				type_d       = '0;
				chk_msb_d    = '0;
				crc_ctl.load = 1'b1;
				pos_d        = PosSrc;
			end else begin
				status_d = ST_INVALID;
			end
		end else if (pos_q == PosSrc) begin
			src_d          = rx_byte;
			crc_ctl.update = 1'b1;
			pos_d          = PosDst;
		end else if (pos_q == PosDst) begin
			dst_d          = rx_byte;
			crc_ctl.update = 1'b1;
			pos_d          = PosLen;
			if (rx_byte != own_addr_q) begin
				status_d = ST_WRONG_ADR;  // keep parsing anyway
			end
		end else if (pos_q == PosLen) begin
			if (rx_byte > max_len_q) begin
				pos_d    = PosStart;
				status_d = ST_INVALID;
			end else begin
				len_d          = rx_byte;
				crc_ctl.update = 1'b1;
				pos_d          = PosType;
			end
		end else if (pos_q == PosType) begin
			type_d         = rx_byte;
			crc_ctl.update = 1'b1;
			pos_d          = pos_inc;
		end else if (pos_q < pay_end) begin
			crc_ctl.update = 1'b1;
			pvalid_d       = 1'b1;
			pindex_d       = ByteW'(pos_q - (PosType + PosW'(1)));
			pos_d          = pos_inc;
		end else if (pos_q == pay_end) begin
			chk_msb_d = rx_byte;
			pos_d     = pos_inc;
		end else if (pos_q == pay_end + PosW'(1)) begin
			pos_d    = PosStart;
			status_d = ({chk_msb_q, rx_byte} == crc) ? ST_READY : ST_INVALID;
		end else begin
			// position past the frame: not reached in normal flow
			pos_d    = PosStart;
			status_d = ST_ERROR;
		end

		if (!accept) begin
			crc_ctl = '0;
		end
	end

	fprx_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.seed   (crc_seed_q),
		.data   (rx_byte),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= '0;
			start_val_q <= 8'd126;
			crc_seed_q  <= '0;
			max_len_q   <= 8'd64;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OWN_ADDR: own_addr_q  <= cfg_data[ByteW-1:0];
				CFG_START:    start_val_q <= cfg_data[ByteW-1:0];
				CFG_CRC_SEED: crc_seed_q  <= cfg_data[CrcW-1:0];
				CFG_MAX_LEN:  max_len_q   <= cfg_data[ByteW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			len_q     <= '0;
			type_q    <= '0;
			chk_msb_q <= '0;
		end else if (accept) begin
			pos_q     <= pos_d;
			src_q     <= src_d;
			dst_q     <= dst_d;
			len_q     <= len_d;
			type_q    <= type_d;
			chk_msb_q <= chk_msb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			pvalid_q   <= pvalid_d;
			pbyte_q    <= pvalid_d ? rx_byte : '0;
			pindex_q   <= pindex_d;
			src_out_q  <= src_d;
			dst_out_q  <= dst_d;
			len_out_q  <= len_d;
			type_out_q <= type_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_valid  = pvalid_q;
	assign payload_byte   = pbyte_q;
	assign payload_index  = pindex_q;
	assign source_address = src_out_q;
	assign dest_address   = dst_out_q;
	assign payload_length = len_out_q;
	assign packet_type    = type_out_q;

	// an accepted restart parks the parser at the start position
	a_restart_park: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (pos_q == PosStart))
		else $error("restart did not clear parse position");

	// a payload byte never carries a terminal status
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pvalid_q) |-> (status_q == ST_NOT_READY))
		else $error("payload byte reported with non-idle status");

	// payload index stays inside the advertised length
	a_payload_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pvalid_q) |-> (pindex_q < len_out_q))
		else $error("payload index beyond length");

	// parse position never runs past the check LSB of the current frame
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= pay_end + PosW'(1))
		else $error("parse position beyond frame");

	// a frame verdict returns the parser to the start position
	a_verdict_park: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !restart && pos_q != PosStart &&
			(status_d == ST_READY || status_d == ST_INVALID)) |=> (pos_q == PosStart))
		else $error("parser did not return to start after verdict");

endmodule
